// ----- rtl/psc_pkg.sv -----
// ============================================================================
// psc_pkg
// Shared types and constants for the PID steering controller.
// ============================================================================
package psc_pkg;

    // Widths of the word fields and of the internal datapath
    localparam int ERR_W    = 16;              // Q8.8 error sample
    localparam int DIFF_W   = ERR_W + 1;       // error difference
    localparam int SUM_W    = 32;              // saturating error sum
    localparam int GAIN_W   = 16;              // Q8.8 gain
    localparam int PROD_P_W = GAIN_W + ERR_W;  // Kp * error
    localparam int PROD_I_W = GAIN_W + SUM_W;  // Ki * sum
    localparam int PROD_D_W = GAIN_W + DIFF_W; // Kd * difference
    localparam int CMD_W    = PROD_I_W + 2;    // sum of three products, negated
    localparam int DRIVE_W  = 16;              // Q1.14 command

    // Depth of the queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    // Clamp limits: +/-1.0 in Q34.16 and in Q1.14
    localparam logic signed [CMD_W-1:0]   CMD_POS_ONE   = CMD_W'(65536);
    localparam logic signed [CMD_W-1:0]   CMD_NEG_ONE   = -CMD_W'(65536);
    localparam logic signed [DRIVE_W-1:0] DRIVE_POS_ONE = DRIVE_W'(16384);
    localparam logic signed [DRIVE_W-1:0] DRIVE_NEG_ONE = -DRIVE_W'(16384);

    // Register map (word index = paddr / 4)
    typedef enum logic [1:0] {
        REG_GAIN_P = 2'd0,
        REG_GAIN_I = 2'd1,
        REG_GAIN_D = 2'd2
    } reg_idx_t;

    // One classified sample, handed from front to back end
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic signed [SUM_W-1:0]  sum;
    } item_t;

endpackage

// ----- rtl/pid_steering_controller.sv -----
// ============================================================================
// pid_steering_controller
// PID steering controller with Q1.14 output clamp.
// ============================================================================
// Usage:
//  - Input channel (in_valid/in_ready/error_sample): one signed Q8.8 error
//    word per transfer. The front end updates previous error and the
//    saturating 32-bit error sum on the accepting edge.
//  - Output channel (out_valid/out_ready/drive_value/clamped): one word per
//    input word, in order. drive_value = -(Kp*e + Ki*sum + Kd*diff) in Q1.14,
//    floored, limited to +/-1.0; clamped flags a limited result.
//  - Gains live in APB registers: 0x0 Kp, 0x4 Ki, 0x8 Kd (signed Q8.8,
//    low 16 bits of pwdata). Write them only while no word is in flight.
//  - Path: the accepting edge writes the queue; the word then passes the
//    product, sum and clamp/output registers before out_valid rises.
//  - Throughput: one word per cycle while out_ready is high; the three
//    multipliers are each used once per word and the output register
//    frees every cycle it is taken.
//  - Stall: when out_ready is low the back-end pipeline holds; the queue
//    between front and back keeps taking words until it is full, then
//    in_ready drops.
//  - Reset: gains, previous error and error sum go to zero, queue and
//    pipeline empty.
// ============================================================================
module pid_steering_controller
#(
    parameter int QueueDepth = psc_pkg::QUEUE_DEPTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input word channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [psc_pkg::ERR_W-1:0]     error_sample,
    // output word channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [psc_pkg::DRIVE_W-1:0]   drive_value,
    output logic                                 clamped,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int GainW = psc_pkg::GAIN_W;

    // gain registers
    logic signed [GainW-1:0] gain_p_reg;
    logic signed [GainW-1:0] gain_i_reg;
    logic signed [GainW-1:0] gain_d_reg;
    logic                    cfg_write;
    psc_pkg::reg_idx_t       cfg_idx;

    // front -> queue -> back
    logic           push;
    psc_pkg::item_t push_item;
    logic           queue_full;
    logic           head_valid;
    psc_pkg::item_t head_item;
    logic           pop;

    // ------------------------------------------------------------------
    // APB: zero wait state, write on access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = psc_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                psc_pkg::REG_GAIN_P: gain_p_reg <= pwdata[GainW-1:0];
                psc_pkg::REG_GAIN_I: gain_i_reg <= pwdata[GainW-1:0];
                psc_pkg::REG_GAIN_D: gain_d_reg <= pwdata[GainW-1:0];
                default:             ; // unmapped address, write dropped
            endcase
        end
    end

    // read data: gains sign-extended to the bus width
    always_comb
    begin
        case (cfg_idx)
            psc_pkg::REG_GAIN_P: prdata = 32'(gain_p_reg);
            psc_pkg::REG_GAIN_I: prdata = 32'(gain_i_reg);
            psc_pkg::REG_GAIN_D: prdata = 32'(gain_d_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front end: accept word, update error state
    // ------------------------------------------------------------------
    psc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .error_sample (error_sample),
        .queue_full   (queue_full),
        .push         (push),
        .push_item    (push_item)
    );

    // ------------------------------------------------------------------
    // Decoupling queue
    // ------------------------------------------------------------------
    psc_queue #(
        .Depth (QueueDepth)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    // ------------------------------------------------------------------
    // Back end: multiply, sum, clamp
    // ------------------------------------------------------------------
    psc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (head_valid),
        .in_ready    (pop),
        .in_item     (head_item),
        .gain_p      (gain_p_reg),
        .gain_i      (gain_i_reg),
        .gain_d      (gain_d_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive_value (drive_value),
        .clamped     (clamped)
    );

endmodule

// ----- rtl/psc_front.sv -----
// ============================================================================
// psc_front
// Accepts error words, updates previous error and saturating error sum.
// ============================================================================
module psc_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [psc_pkg::ERR_W-1:0]    error_sample,
    input  logic                                queue_full,
    output logic                                push,
    output psc_pkg::item_t                      push_item
);

    localparam int ErrW = psc_pkg::ERR_W;
    localparam int SumW = psc_pkg::SUM_W;

    logic signed [ErrW-1:0]  prev_reg;
    logic signed [ErrW-1:0]  prev_next;
    logic signed [SumW-1:0]  sum_reg;
    logic signed [SumW-1:0]  sum_next;
    logic signed [SumW:0]    sum_wide;
    logic                    accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        sum_wide = {sum_reg[SumW-1], sum_reg} + (SumW + 1)'(error_sample);
        // saturate when the 33-bit sum leaves the 32-bit range
        if (sum_wide[SumW] != sum_wide[SumW-1])
        begin
            sum_next = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}}
                                      : {1'b0, {(SumW-1){1'b1}}};
        end
        else
        begin
            sum_next = sum_wide[SumW-1:0];
        end
        prev_next = error_sample;

        push           = accept;
        push_item.err  = error_sample;
        push_item.diff = (ErrW + 1)'(error_sample) - (ErrW + 1)'(prev_reg);
        push_item.sum  = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            sum_reg  <= '0;
        end
        else if (accept)
        begin
            prev_reg <= prev_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

// ----- rtl/psc_queue.sv -----
// ============================================================================
// psc_queue
// Small show-ahead queue between front and back end.
// ============================================================================
module psc_queue
#(
    parameter int Depth = psc_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  psc_pkg::item_t push_item,
    output logic           full,
    output logic           head_valid,
    output psc_pkg::item_t head_item,
    input  logic           pop
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    psc_pkg::item_t  mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/psc_back.sv -----
// ============================================================================
// psc_back
// Three-stage datapath: products, sum, negate and clamp to Q1.14.
// ============================================================================
module psc_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  psc_pkg::item_t                       in_item,
    input  logic signed [psc_pkg::GAIN_W-1:0]    gain_p,
    input  logic signed [psc_pkg::GAIN_W-1:0]    gain_i,
    input  logic signed [psc_pkg::GAIN_W-1:0]    gain_d,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [psc_pkg::DRIVE_W-1:0]   drive_value,
    output logic                                 clamped
);

    localparam int PW     = psc_pkg::PROD_P_W;
    localparam int IW     = psc_pkg::PROD_I_W;
    localparam int DW     = psc_pkg::PROD_D_W;
    localparam int CmdW   = psc_pkg::CMD_W;
    localparam int DriveW = psc_pkg::DRIVE_W;

    // stage 1: products
    logic                   v1_reg;
    logic signed [PW-1:0]   p1_reg;
    logic signed [IW-1:0]   i1_reg;
    logic signed [DW-1:0]   d1_reg;
    logic signed [PW-1:0]   p1_next;
    logic signed [IW-1:0]   i1_next;
    logic signed [DW-1:0]   d1_next;
    // stage 2: total
    logic                   v2_reg;
    logic signed [CmdW-1:0] total_reg;
    logic signed [CmdW-1:0] total_next;
    // stage 3: output
    logic                   v3_reg;
    logic signed [DriveW-1:0] drive_reg;
    logic signed [DriveW-1:0] drive_next;
    logic                   clamp_reg;
    logic                   clamp_next;
    logic signed [CmdW-1:0] cmd;
    logic                   adv1;
    logic                   adv2;
    logic                   adv3;

    // each stage moves when it is empty or the next one moves
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        p1_next = PW'(gain_p) * PW'(in_item.err);
        i1_next = IW'(gain_i) * IW'(in_item.sum);
        d1_next = DW'(gain_d) * DW'(in_item.diff);

        total_next = CmdW'(p1_reg) + CmdW'(i1_reg) + CmdW'(d1_reg);

        cmd = -total_reg;
        if (cmd > psc_pkg::CMD_POS_ONE)
        begin
            drive_next = psc_pkg::DRIVE_POS_ONE;
            clamp_next = 1'b1;
        end
        else if (cmd < psc_pkg::CMD_NEG_ONE)
        begin
            drive_next = psc_pkg::DRIVE_NEG_ONE;
            clamp_next = 1'b1;
        end
        else
        begin
            // floor shift Q34.16 -> Q1.14
            drive_next = cmd[DriveW+1:2];
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            p1_reg <= p1_next;
            i1_reg <= i1_next;
            d1_reg <= d1_next;
        end
        if (adv2 && v1_reg)
        begin
            total_reg <= total_next;
        end
        if (adv3 && v2_reg)
        begin
            drive_reg <= drive_next;
            clamp_reg <= clamp_next;
        end
    end

    assign out_valid   = v3_reg;
    assign drive_value = drive_reg;
    assign clamped     = clamp_reg;

endmodule
